// ----- src/jls_pkg.sv -----
// ----------------------------------------------------------------------------
// jls_pkg: shared types and codes for the Jacobi/Legendre symbol unit
// Status codes, mode codes and the control word that travels through the
// job queue between the front and back parts.
// ----------------------------------------------------------------------------
package jls_pkg;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_BAD_MOD = 2'd1;
   localparam logic [1:0] ST_BAD_ARG = 2'd2;

   localparam logic FUNC_JACOBI   = 1'b0;
   localparam logic FUNC_LEGENDRE = 1'b1;

   localparam logic [1:0] SYM_ZERO = 2'b00;
   localparam logic [1:0] SYM_POS  = 2'b01;
   localparam logic [1:0] SYM_NEG  = 2'b11;

   // Control part of one queued job. A job that is already decided by the
   // front carries done = 1 and its final symbol and status.
   typedef struct packed {
      logic       done;
      logic       neg;
      logic [1:0] symbol;
      logic [1:0] status;
   } job_ctl_type;

   localparam int CTL_W = $bits(job_ctl_type);

endpackage

// ----- src/jls_if.sv -----
// ----------------------------------------------------------------------------
// jls_req_if / jls_rsp_if: valid/ready channels of the symbol unit
// One interface for the request channel and one for the response channel.
// ----------------------------------------------------------------------------
interface jls_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [63:0] a_value;
   logic [62:0] n_value;

   modport source (output valid, output func, output a_value, output n_value,
                   input ready);
   modport sink   (input valid, input func, input a_value, input n_value,
                   output ready);
endinterface

interface jls_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] symbol;
   logic [1:0] status;

   modport source (output valid, output symbol, output status, input ready);
   modport sink   (input valid, input symbol, input status, output ready);
endinterface

// ----- src/jls_front.sv -----
// ----------------------------------------------------------------------------
// jls_front: request classification
// Checks mode, range and modulus, decides trivial cases and forms the
// magnitude and modulus of jobs that need a reduction.
// ----------------------------------------------------------------------------
module jls_front #(
   parameter int WIDTH = 64
) (
   input  logic                 func,
   input  logic [63:0]          a_value,
   input  logic [62:0]          n_value,
   output jls_pkg::job_ctl_type ctl,
   output logic [WIDTH-1:0]     mag,
   output logic [WIDTH-2:0]     nv
);
   import jls_pkg::*;

   logic [WIDTH-1:0] av;
   logic             neg;
   logic             nv_zero;
   logic             nv_even;

   always_comb begin
      av      = a_value[WIDTH-1:0];
      neg     = av[WIDTH-1];
      mag     = neg ? (~av + WIDTH'(1)) : av;
      nv      = n_value[WIDTH-2:0];
      nv_zero = (nv == '0);
      nv_even = ~nv[0];

      ctl.done   = 1'b0;
      ctl.neg    = neg;
      ctl.symbol = SYM_ZERO;
      ctl.status = ST_OK;

      if (func == FUNC_LEGENDRE) begin
         if (neg || (mag > {1'b0, nv})) begin
            ctl.done   = 1'b1;
            ctl.status = ST_BAD_ARG;
         end else if (nv_zero || (nv_even && (nv != (WIDTH-1)'(2)))) begin
            ctl.done   = 1'b1;
            ctl.status = ST_BAD_MOD;
         end
      end else begin
         if (nv_zero || nv_even) begin
            ctl.done   = 1'b1;
            ctl.status = ST_BAD_MOD;
         end else if (nv == (WIDTH-1)'(1)) begin
            ctl.done   = 1'b1;
            ctl.symbol = SYM_POS;
         end
      end
   end

endmodule

// ----- src/jls_queue.sv -----
// ----------------------------------------------------------------------------
// jls_queue: two-entry job queue
// Decouples request classification from the reduction engine.
// ----------------------------------------------------------------------------
module jls_queue #(
   parameter int DATA_W = 134
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  logic [DATA_W-1:0] push_data,
   output logic              full,
   input  logic              pop,
   output logic [DATA_W-1:0] pop_data,
   output logic              empty
);
   logic [DATA_W-1:0] slot_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push) else $error("push into full job queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      empty |-> !pop) else $error("pop from empty job queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3) else $error("job queue count out of range");
`endif

endmodule

// ----- src/jls_back.sv -----
// ----------------------------------------------------------------------------
// jls_back: reduction engine
// Runs the remainder, halving and reciprocity steps on one job and holds
// the result in an output register.
// ----------------------------------------------------------------------------
module jls_back #(
   parameter int WIDTH = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_avail,
   input  jls_pkg::job_ctl_type job_ctl,
   input  logic [WIDTH-1:0]     job_mag,
   input  logic [WIDTH-2:0]     job_nv,
   output logic                 job_pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [1:0]           rsp_symbol,
   output logic [1:0]           rsp_status
);
   import jls_pkg::*;

   localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_MOD   = 2'd1;
   localparam logic [1:0] S_CHECK = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [WIDTH-1:0] top_ff, top_in;
   logic [WIDTH-1:0] bottom_ff, bottom_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             sign_ff, sign_in;
   logic             first_ff, first_in;
   logic             neg_ff, neg_in;
   logic [1:0]       sym_ff, sym_in;
   logic [1:0]       stat_ff, stat_in;
   logic             out_valid_ff, out_valid_in;
   logic [1:0]       out_sym_ff, out_sym_in;
   logic [1:0]       out_stat_ff, out_stat_in;

   logic [WIDTH-1:0] rem_shift;
   logic [WIDTH-1:0] rem_next;
   logic             out_free;

   assign out_free   = !out_valid_ff || rsp_ready;
   assign rsp_valid  = out_valid_ff;
   assign rsp_symbol = out_sym_ff;
   assign rsp_status = out_stat_ff;
   assign job_pop    = (state_ff == S_IDLE) && job_avail;

   always_comb begin
      rem_shift = {rem_ff[WIDTH-2:0], top_ff[WIDTH-1]};
      rem_next  = (rem_shift >= bottom_ff) ? (rem_shift - bottom_ff) : rem_shift;

      state_in     = state_ff;
      top_in       = top_ff;
      bottom_in    = bottom_ff;
      rem_in       = rem_ff;
      cnt_in       = '0;
      sign_in      = sign_ff;
      first_in     = first_ff;
      neg_in       = neg_ff;
      sym_in       = sym_ff;
      stat_in      = stat_ff;
      out_valid_in = out_valid_ff && !rsp_ready;
      out_sym_in   = out_sym_ff;
      out_stat_in  = out_stat_ff;

      case (state_ff)
         S_IDLE: begin
            if (job_avail) begin
               sym_in  = job_ctl.symbol;
               stat_in = job_ctl.status;
               if (job_ctl.done) begin
                  state_in = S_DONE;
               end else begin
                  top_in    = job_mag;
                  bottom_in = {1'b0, job_nv};
                  rem_in    = '0;
                  sign_in   = 1'b0;
                  first_in  = 1'b1;
                  neg_in    = job_ctl.neg;
                  state_in  = S_MOD;
               end
            end
         end
         S_MOD: begin
            rem_in = rem_next;
            top_in = {top_ff[WIDTH-2:0], 1'b0};
            cnt_in = cnt_ff + CW'(1);
            if (cnt_ff == CW'(WIDTH-1)) begin
               cnt_in = '0;
               rem_in = '0;
               // A negative numerator maps to the modulus minus its remainder, if that is not zero.
               if (first_ff && neg_ff && (rem_next != '0)) begin
                  top_in = bottom_ff - rem_next;
               end else begin
                  top_in = rem_next;
               end
               first_in = 1'b0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            if (top_ff == '0) begin
               sym_in   = SYM_ZERO;
               state_in = S_DONE;
            end else if (top_ff == WIDTH'(1)) begin
               sym_in   = sign_ff ? SYM_NEG : SYM_POS;
               state_in = S_DONE;
            end else if (!top_ff[0]) begin
               top_in = {1'b0, top_ff[WIDTH-1:1]};
               if ((bottom_ff[2:0] == 3'd3) || (bottom_ff[2:0] == 3'd5)) begin
                  sign_in = ~sign_ff;
               end
            end else begin
               if ((top_ff[1:0] == 2'd3) && (bottom_ff[1:0] == 2'd3)) begin
                  sign_in = ~sign_ff;
               end
               top_in    = bottom_ff;
               bottom_in = top_ff;
               state_in  = S_MOD;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_sym_in   = sym_ff;
               out_stat_in  = stat_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         out_valid_ff <= 1'b0;
         top_ff       <= '0;
         bottom_ff    <= '0;
         sign_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         out_valid_ff <= out_valid_in;
         top_ff       <= top_in;
         bottom_ff    <= bottom_in;
         sign_ff      <= sign_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff      <= rem_in;
      first_ff    <= first_in;
      neg_ff      <= neg_in;
      sym_ff      <= sym_in;
      stat_ff     <= stat_in;
      out_sym_ff  <= out_sym_in;
      out_stat_ff <= out_stat_in;
   end

`ifndef ASSERT_OFF
   a_check_reduced: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (top_ff < bottom_ff))
      else $error("numerator not reduced below modulus");
   a_check_modulus: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_CHECK) |-> (bottom_ff[0] || (bottom_ff == WIDTH'(2))))
      else $error("modulus even during reduction");
   a_cnt_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_MOD) |-> (cnt_ff == '0))
      else $error("bit counter running outside remainder step");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp_ready) |=> (out_valid_ff && $stable(out_sym_ff)))
      else $error("pending result lost");
`endif

endmodule

// ----- src/jacobi_legendre_symbol_unit_top.sv -----
// ----------------------------------------------------------------------------
// jacobi_legendre_symbol_unit_top: Jacobi / Legendre symbol unit
// Computes (a/n) as -1, 0 or 1 with a status code, one request at a time.
// ----------------------------------------------------------------------------
//
// Channel   Dir  Payload                          Transfer when
// req_ch    in   func, a_value, n_value           valid && ready
// rsp_ch    out  symbol, status                   valid && ready
//
// A request that the front part decides on its own (bad range, bad modulus,
// unit modulus in Jacobi mode) goes from the queue to the output register
// without a reduction. Every other request runs remainder steps on a
// one-bit-per-cycle restoring remainder unit, with halving and swap steps
// between them; the number of such steps depends on the operands.
// Reset is synchronous and clears the queue, the engine and the output.
// The two-entry job queue lets requests be accepted while the engine works
// and while a response waits to be taken.
module jacobi_legendre_symbol_unit_top #(
   parameter int WIDTH = 64
) (
   input  logic      clock,
   input  logic      reset,
   jls_req_if.sink   req_ch,
   jls_rsp_if.source rsp_ch
);
   import jls_pkg::*;

   // Queue entry: control word, numerator magnitude, modulus.
   localparam int QW = CTL_W + WIDTH + WIDTH - 1;

   job_ctl_type      front_ctl;
   logic [WIDTH-1:0] front_mag;
   logic [WIDTH-2:0] front_nv;

   logic             q_full;
   logic             q_empty;
   logic             q_push;
   logic             q_pop;
   logic [QW-1:0]    q_out;

   job_ctl_type      back_ctl;
   logic [WIDTH-1:0] back_mag;
   logic [WIDTH-2:0] back_nv;

   // The front classifies the request combinationally; it is taken whenever
   // the queue has room.
   jls_front #(.WIDTH(WIDTH)) u_front (
      .func    (req_ch.func),
      .a_value (req_ch.a_value),
      .n_value (req_ch.n_value),
      .ctl     (front_ctl),
      .mag     (front_mag),
      .nv      (front_nv)
   );

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full;

   jls_queue #(.DATA_W(QW)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data ({front_ctl, front_mag, front_nv}),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_out),
      .empty     (q_empty)
   );

   assign {back_ctl, back_mag, back_nv} = q_out;

   // The back engine pops one job, reduces it and parks the result in its
   // output register until the response transfer.
   jls_back #(.WIDTH(WIDTH)) u_back (
      .clock      (clock),
      .reset      (reset),
      .job_avail  (!q_empty),
      .job_ctl    (back_ctl),
      .job_mag    (back_mag),
      .job_nv     (back_nv),
      .job_pop    (q_pop),
      .rsp_valid  (rsp_ch.valid),
      .rsp_ready  (rsp_ch.ready),
      .rsp_symbol (rsp_ch.symbol),
      .rsp_status (rsp_ch.status)
   );

endmodule
